// ----- rtl/dbs_pkg.sv -----
// ----------------------------------------------------------------------------
// dbs_pkg
// Shared constants, types and keyword tables for the directive and brace
// stripper.
// ----------------------------------------------------------------------------
package dbs_pkg;

    localparam int DBS_MAX_NEST_DEPTH = 255;

    localparam logic [7:0] CHAR_HASH    = 8'h23;
    localparam logic [7:0] CHAR_LBRACE  = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE  = 8'h7D;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [2:0] KW_LEN = 3'd6;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NESTED    = 2'd1;
    localparam logic [1:0] STATUS_ENDDEF    = 2'd2;
    localparam logic [1:0] STATUS_UNMATCHED = 2'd3;

    typedef struct packed {
        logic       keep;
        logic [1:0] status;
    } dbs_result_t;

    // "define", clamped at its last letter
    function automatic logic [7:0] kw_define_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h64;
            3'd1:    ch = 8'h65;
            3'd2:    ch = 8'h66;
            3'd3:    ch = 8'h69;
            3'd4:    ch = 8'h6E;
            default: ch = 8'h65;
        endcase
        return ch;
    endfunction

    // "enddef", clamped at its last letter
    function automatic logic [7:0] kw_enddef_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h65;
            3'd1:    ch = 8'h6E;
            3'd2:    ch = 8'h64;
            3'd3:    ch = 8'h64;
            3'd4:    ch = 8'h65;
            default: ch = 8'h66;
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/dbs_filter.sv -----
// ----------------------------------------------------------------------------
// dbs_filter
// Scanner state: directive phase, keyword match, define mode, brace depth and
// the latched error. Gives keep and status for the word being accepted.
// ----------------------------------------------------------------------------
module dbs_filter #(
    parameter int MAX_NEST_DEPTH = dbs_pkg::DBS_MAX_NEST_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    output dbs_pkg::dbs_result_t result
);

    localparam int DepthW = $clog2(MAX_NEST_DEPTH + 1);
    localparam logic [DepthW-1:0] DepthMax = DepthW'(MAX_NEST_DEPTH);

    localparam logic [1:0] PH_NORMAL  = 2'd0;
    localparam logic [1:0] PH_MATCH   = 2'd1;
    localparam logic [1:0] PH_SWALLOW = 2'd2;
    localparam logic [1:0] PH_SPARE   = 2'd3;

    logic              in_define_reg, in_define_next;
    logic [DepthW-1:0] depth_reg, depth_next;
    logic [1:0]        phase_reg, phase_next;
    logic [2:0]        pos_reg, pos_next;
    logic              may_def_reg, may_def_next;
    logic              may_end_reg, may_end_next;
    logic [1:0]        error_reg, error_next;
    logic              keep_c;
    logic              def_hit, end_hit;

    assign def_hit = may_def_reg && (in_byte == dbs_pkg::kw_define_char(pos_reg));
    assign end_hit = may_end_reg && (in_byte == dbs_pkg::kw_enddef_char(pos_reg));

    always_comb
    begin
        in_define_next = in_define_reg;
        depth_next     = depth_reg;
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        may_def_next   = may_def_reg;
        may_end_next   = may_end_reg;
        error_next     = error_reg;
        keep_c         = 1'b0;
        if (accept && error_reg == dbs_pkg::STATUS_OK)
        begin
            unique case (phase_reg) inside
                PH_MATCH:
                begin
                    if (in_byte == dbs_pkg::CHAR_NEWLINE)
                    begin
                        phase_next = PH_NORMAL;
                    end
                    else
                    begin
                        may_def_next = def_hit;
                        may_end_next = end_hit;
                        pos_next     = pos_reg + 3'd1;
                        // sixth letter decides the keyword
                        if (pos_reg + 3'd1 >= dbs_pkg::KW_LEN)
                        begin
                            phase_next = PH_SWALLOW;
                            if (def_hit)
                            begin
                                if (in_define_reg)
                                    error_next = dbs_pkg::STATUS_NESTED;
                                else
                                    in_define_next = 1'b1;
                            end
                            else if (end_hit)
                            begin
                                if (!in_define_reg)
                                    error_next = dbs_pkg::STATUS_ENDDEF;
                                else
                                    in_define_next = 1'b0;
                            end
                        end
                    end
                end
                PH_SWALLOW, PH_SPARE:
                begin
                    if (in_byte == dbs_pkg::CHAR_NEWLINE)
                        phase_next = PH_NORMAL;
                end
                default:
                begin
                    case (in_byte)
                        dbs_pkg::CHAR_HASH:
                        begin
                            phase_next   = PH_MATCH;
                            pos_next     = 3'd0;
                            may_def_next = 1'b1;
                            may_end_next = 1'b1;
                        end
                        dbs_pkg::CHAR_LBRACE:
                        begin
                            if (depth_reg < DepthMax)
                                depth_next = depth_reg + DepthW'(1);
                        end
                        dbs_pkg::CHAR_RBRACE:
                        begin
                            if (depth_reg == '0)
                                error_next = dbs_pkg::STATUS_UNMATCHED;
                            else
                                depth_next = depth_reg - DepthW'(1);
                        end
                        default:
                        begin
                            keep_c = !in_define_reg && (depth_reg == '0);
                        end
                    endcase
                end
            endcase
        end
    end

    assign result.keep   = keep_c;
    assign result.status = error_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_define_reg <= 1'b0;
            depth_reg     <= '0;
            phase_reg     <= PH_NORMAL;
            pos_reg       <= 3'd0;
            may_def_reg   <= 1'b1;
            may_end_reg   <= 1'b1;
            error_reg     <= dbs_pkg::STATUS_OK;
        end
        else
        begin
            in_define_reg <= in_define_next;
            depth_reg     <= depth_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            may_def_reg   <= may_def_next;
            may_end_reg   <= may_end_next;
            error_reg     <= error_next;
        end
    end

`ifndef SYNTHESIS
    // a latched error freezes the scanner
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg != dbs_pkg::STATUS_OK |=>
            error_reg == $past(error_reg) && depth_reg == $past(depth_reg)
            && in_define_reg == $past(in_define_reg))
        else $error("state moved after error");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DepthMax)
        else $error("depth beyond maximum");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_MATCH |-> pos_reg < dbs_pkg::KW_LEN)
        else $error("keyword position overrun");

    a_keep_ok: assert property (@(posedge clk) disable iff (!rst_n)
        keep_c |-> error_next == dbs_pkg::STATUS_OK && phase_reg == PH_NORMAL)
        else $error("word kept in directive or error");
`endif

endmodule

// ----- rtl/directive_and_brace_stripper.sv -----
// ----------------------------------------------------------------------------
// directive_and_brace_stripper
// Byte stream filter dropping preprocessor directive lines and braced blocks,
// with define/enddef tracking and sticky error reporting.
// ----------------------------------------------------------------------------
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------
//   input    | in_valid / in_ready | in_byte
//   output   | out_valid/ out_ready| keep, out_byte, status
//
// One word per clock unless a full output register is stalled; each word's
// result is registered in the single output register on acceptance.
// in_ready stays high while the output register is empty or being drained.
// Asynchronous reset clears scanner state and the output valid flag.
// ----------------------------------------------------------------------------
module directive_and_brace_stripper #(
    parameter int MAX_NEST_DEPTH = dbs_pkg::DBS_MAX_NEST_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       keep,
    output logic [7:0] out_byte,
    output logic [1:0] status
);

    logic                accept;
    dbs_pkg::dbs_result_t result;
    logic                out_valid_reg;
    logic                keep_reg;
    logic [7:0]          byte_reg;
    logic [1:0]          status_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    dbs_filter #(
        .MAX_NEST_DEPTH(MAX_NEST_DEPTH)
    ) u_filter (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            keep_reg   <= result.keep;
            byte_reg   <= in_byte;
            status_reg <= result.status;
        end
    end

    assign out_valid = out_valid_reg;
    assign keep      = keep_reg;
    assign out_byte  = byte_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !accept)
        else $error("word accepted over a stalled result");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg && out_byte == $past(in_byte))
        else $error("result register not loaded");

    a_keep_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && keep_reg |-> status_reg == dbs_pkg::STATUS_OK)
        else $error("kept word carries error status");
`endif

endmodule
